// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the key press/release tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge once reset is released.
`define KPRT_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define KPRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/kprt_pkg.sv -----
// Types and constants of the key press/release tracker.
`default_nettype none

package kprt_pkg;

	localparam int NUM_CODES_DEF     = 224;
	localparam int KEYS_PER_SCAN_DEF = 10;
	localparam int MAX_RESULTS       = 20;
	localparam int RES_CNT_W         = $clog2(MAX_RESULTS + 1);
	localparam int HITS_W            = 4;
	localparam int CODE_W            = 8;
	localparam int STATUS_W          = 2;

	// Bit positions inside one key status entry.
	localparam int HIT_BIT  = 0;
	localparam int HELD_BIT = 1;

	// Input action codes.
	localparam logic ACT_HIT = 1'b0;
	localparam logic ACT_END = 1'b1;

	typedef struct packed {
		logic              action;
		logic [CODE_W-1:0] key_code;
	} kprt_in_t;

	typedef struct packed {
		logic [CODE_W-1:0] event_code;
		logic              is_press;
		logic              last;
	} kprt_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HIT_WR,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_FLUSH
	} kprt_state_t;

endpackage

`default_nettype wire

// ----- rtl/kprt_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module kprt_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 224,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/key_press_release_tracker_top.sv -----
// Top level of the key press/release tracker: control sequencer around the key status RAM.
`default_nettype none

// A key hit beat is read from the status RAM in ST_IDLE and written back in ST_HIT_WR.
// An end-of-scan beat starts a walk over all codes through the single status RAM, each code
// read in ST_WALK_RD and handled in ST_WALK_EV, then ST_FLUSH; the walk holds while the output is stalled.
// The first event of a scan waits as the pending event and leaves the block only when the
// walk finds the next event or reaches ST_FLUSH.
// Reset (arst_n low) clears the per-entry valid bits, so every key reads as neither hit nor
// held; no clearing pass runs and the block takes a beat in ST_IDLE straight after reset.

module key_press_release_tracker_top #(
	parameter int NUM_CODES     = kprt_pkg::NUM_CODES_DEF,
	parameter int KEYS_PER_SCAN = kprt_pkg::KEYS_PER_SCAN_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kprt_pkg::kprt_in_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kprt_pkg::kprt_out_t      out_data
);

	import kprt_pkg::*;
`include "assert_macros.svh"

	localparam int AW = (NUM_CODES > 1) ? $clog2(NUM_CODES) : 1;

	kprt_state_t st_q, st_d;

	// Status RAM port signals.
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [STATUS_W-1:0] wr_data, rd_data;

	// One valid bit per entry; an entry that was never written reads as zero.
	logic [NUM_CODES-1:0] vld_q;
	logic                 vld_s1;

	logic [AW-1:0]        code_q;
	logic [AW-1:0]        idx_q;
	logic [HITS_W-1:0]    hits_q;
	logic [RES_CNT_W-1:0] n_q;

	// The pending event waits until the walk knows whether it is the last one.
	logic       pend_v_q;
	kprt_out_t  pend_q;
	logic       out_valid_q;
	kprt_out_t  out_q;

	logic [STATUS_W-1:0] old_st;
	logic                code_ok, hit_ok, is_ev, emit, out_free, stall, idx_last;
	logic                push, push_last, walk_step, start_walk, take_hit;

	kprt_ram #(
		.WIDTH(STATUS_W),
		.DEPTH(NUM_CODES),
		.AW   (AW)
	) u_status_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Decode of the current beat and of the entry read back from the RAM.
	always_comb begin
		code_ok  = ({1'b0, in_data.key_code} < 9'(NUM_CODES));
		hit_ok   = code_ok && (hits_q < HITS_W'(KEYS_PER_SCAN));
		old_st   = vld_s1 ? rd_data : '0;
		is_ev    = old_st[HIT_BIT] ^ old_st[HELD_BIT];
		emit     = is_ev && (n_q < RES_CNT_W'(MAX_RESULTS));
		out_free = !out_valid_q || out_ready;
		// A new event can only displace the pending one if the output register has room.
		stall    = emit && pend_v_q && !out_free;
		idx_last = (idx_q == AW'(NUM_CODES - 1));
	end

	// Next state.
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.action == ACT_END) begin
						st_d = ST_WALK_RD;
					end else if (hit_ok) begin
						st_d = ST_HIT_WR;
					end
				end
			end
			ST_HIT_WR: st_d = ST_IDLE;
			ST_WALK_RD: st_d = ST_WALK_EV;
			ST_WALK_EV: begin
				if (!stall) begin
					st_d = idx_last ? ST_FLUSH : ST_WALK_RD;
				end
			end
			ST_FLUSH: begin
				if (!pend_v_q || out_free) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = idx_q;
		wr_en      = 1'b0;
		wr_addr    = idx_q;
		wr_data    = '0;
		push       = 1'b0;
		push_last  = 1'b0;
		walk_step  = 1'b0;
		start_walk = 1'b0;
		take_hit   = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = in_data.key_code[AW-1:0];
				if (in_valid && in_data.action == ACT_END) begin
					start_walk = 1'b1;
				end else if (in_valid && hit_ok) begin
					take_hit = 1'b1;
					rd_en    = 1'b1;
				end
			end
			ST_HIT_WR: begin
				wr_en   = 1'b1;
				wr_addr = code_q;
				wr_data[HIT_BIT]  = 1'b1;
				wr_data[HELD_BIT] = old_st[HELD_BIT];
			end
			ST_WALK_RD: begin
				rd_en = 1'b1;
			end
			ST_WALK_EV: begin
				if (!stall) begin
					walk_step = 1'b1;
					wr_en     = 1'b1;
					// Held exactly when hit in this scan; the hit mark is cleared.
					wr_data[HELD_BIT] = old_st[HIT_BIT];
					push      = emit && pend_v_q;
				end
			end
			ST_FLUSH: begin
				push      = pend_v_q && out_free;
				push_last = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			vld_q       <= '0;
			vld_s1      <= 1'b0;
			idx_q       <= '0;
			hits_q      <= '0;
			n_q         <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
			end
			if (take_hit) begin
				hits_q <= hits_q + 1'b1;
			end
			if (start_walk) begin
				idx_q <= '0;
				n_q   <= '0;
			end
			if (walk_step) begin
				idx_q <= idx_q + 1'b1;
				if (emit) begin
					n_q      <= n_q + 1'b1;
					pend_v_q <= 1'b1;
				end
				if (idx_last) begin
					hits_q <= '0;
				end
			end
			if (st_q == ST_FLUSH && push) begin
				pend_v_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (take_hit) begin
			code_q <= in_data.key_code[AW-1:0];
		end
		if (walk_step && emit) begin
			pend_q.event_code <= CODE_W'(idx_q);
			pend_q.is_press   <= old_st[HIT_BIT];
			pend_q.last       <= 1'b0;
		end
		if (push) begin
			out_q.event_code <= pend_q.event_code;
			out_q.is_press   <= pend_q.is_press;
			out_q.last       <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`KPRT_ASSERT(a_res_cap, clk, arst_n, n_q <= RES_CNT_W'(MAX_RESULTS), "event count over limit")
	`KPRT_ASSERT(a_hit_wr_once, clk, arst_n, st_q == ST_HIT_WR |=> st_q == ST_IDLE, "hit wr stuck")
	`KPRT_ASSERT(a_idle_no_pend, clk, arst_n, st_q == ST_IDLE |-> !pend_v_q, "pending event left")
	`KPRT_ASSERT(a_hits_cap, clk, arst_n, hits_q <= HITS_W'(KEYS_PER_SCAN), "hit count over limit")

endmodule

`default_nettype wire
